>>> src/rllm_pkg.sv
// Shared types and status codes for the run length location map.
package rllm_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_LK_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] last;
    logic [31:0] first;
  } region_t;

  typedef struct packed {
    logic    en;
    region_t entry;
  } wr_req_t;

endpackage

>>> src/rllm_region_store.sv
// Region table memory with one write port and one registered read port.
module rllm_region_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic                 clk_i,
  input  rllm_pkg::wr_req_t    wr_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output rllm_pkg::region_t    rd_entry_o
);

  rllm_pkg::region_t mem [Depth];
  rllm_pkg::region_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

>>> src/run_length_location_map.sv
// Top level of the run length location map: control sequencer and output register.
//
// The block keeps a table of regions (first index, last index, location tag).
// Input transactions arrive on the s_axis channel; tuser carries the operation
// (0 insert, 1 lookup) and tdata carries the instruction index and the tag.
// Each input transaction yields exactly one output transaction on m_axis, with
// the found tag in tdata and the status code in tuser.
// An insert into an empty table goes from acceptance straight to S_OUT, which
// loads the output register; any other insert first reads the newest region in
// S_INS_CHK. A lookup reads one region per cycle from the table memory, oldest
// first, in S_LK_SCAN, until a hit or until all stored regions have been read;
// a lookup on an empty table reads none and goes straight to S_OUT.
// The block works on one transaction at a time and accepts the next one in the
// cycle after the result is loaded, even while that result still waits in the
// output register.
// Reset clears the region count and the output valid flag; the table memory
// is not cleared, since only entries below the count are ever read.
// When the receiver stalls, the finished result holds in the output register
// and a following result waits in the sequencer until that register empties.
module run_length_location_map #(
  parameter int MAX_REGIONS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // instr_index [31:0], location_tag [63:32]
  input  logic        s_axis_tuser,  // operation [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // found_tag [31:0]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);

  localparam int AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CntW  = $clog2(MAX_REGIONS + 1);

  rllm_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [31:0]       idx_q, idx_d;
  logic [31:0]       tag_q, tag_d;
  logic [31:0]       res_tag_q, res_tag_d;
  rllm_pkg::status_e res_status_q, res_status_d;
  logic              m_valid_q, m_valid_d;
  logic [31:0]       m_tdata_q, m_tdata_d;
  logic [1:0]        m_tuser_q, m_tuser_d;

  rllm_pkg::wr_req_t wr_req;
  logic [AddrW-1:0]  wr_addr;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  rllm_pkg::region_t rd_entry;

  logic              in_fire;
  logic              out_free;
  logic              in_op;
  logic [31:0]       in_idx;
  logic [31:0]       in_tag;
  logic              count_zero;
  logic              count_full;
  logic [CntW-1:0]   count_m1;
  logic [CntW-1:0]   ptr_p1;
  logic              hit;
  logic              tag_eq;
  logic              last_slot;

  assign in_op      = s_axis_tuser;
  assign in_idx     = s_axis_tdata[31:0];
  assign in_tag     = s_axis_tdata[63:32];
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CntW'(MAX_REGIONS));
  assign count_m1   = count_q - CntW'(1);
  assign ptr_p1     = CntW'(ptr_q) + CntW'(1);
  assign hit        = (rd_entry.first <= idx_q) && (rd_entry.last >= idx_q);
  assign tag_eq     = (rd_entry.tag == tag_q);
  assign last_slot  = (ptr_p1 == count_q);

  rllm_region_store #(
    .Depth (MAX_REGIONS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (wr_req),
    .wr_addr_i  (wr_addr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rllm_pkg::S_IDLE: begin
        if (in_fire) begin
          if (count_zero) begin
            state_d = rllm_pkg::S_OUT;
          end else if (in_op) begin
            state_d = rllm_pkg::S_LK_SCAN;
          end else begin
            state_d = rllm_pkg::S_INS_CHK;
          end
        end
      end
      rllm_pkg::S_INS_CHK: begin
        state_d = rllm_pkg::S_OUT;
      end
      rllm_pkg::S_LK_SCAN: begin
        if (hit || last_slot) begin
          state_d = rllm_pkg::S_OUT;
        end
      end
      rllm_pkg::S_OUT: begin
        if (out_free) begin
          state_d = rllm_pkg::S_IDLE;
        end
      end
      default: state_d = rllm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    wr_req        = '0;
    wr_addr       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    count_d       = count_q;
    ptr_d         = ptr_q;
    idx_d         = idx_q;
    tag_d         = tag_q;
    res_tag_d     = res_tag_q;
    res_status_d  = res_status_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_tdata_d     = m_tdata_q;
    m_tuser_d     = m_tuser_q;
    unique case (state_q)
      rllm_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          idx_d     = in_idx;
          tag_d     = in_tag;
          ptr_d     = '0;
          res_tag_d = '0;
          if (in_op) begin
            rd_en        = !count_zero;
            rd_addr      = '0;
            res_status_d = rllm_pkg::ST_MISS;
          end else if (count_zero) begin
            wr_req.en          = 1'b1;
            wr_req.entry.first = in_idx;
            wr_req.entry.last  = in_idx;
            wr_req.entry.tag   = in_tag;
            wr_addr            = '0;
            count_d            = CntW'(1);
            res_status_d       = rllm_pkg::ST_NEW;
          end else begin
            rd_en   = 1'b1;
            rd_addr = count_m1[AddrW-1:0];
          end
        end
      end
      rllm_pkg::S_INS_CHK: begin
        if (tag_eq) begin
          wr_req.en          = 1'b1;
          wr_req.entry.first = rd_entry.first;
          wr_req.entry.last  = idx_q;
          wr_req.entry.tag   = tag_q;
          wr_addr            = count_m1[AddrW-1:0];
          res_status_d       = rllm_pkg::ST_OK;
        end else if (count_full) begin
          res_status_d = rllm_pkg::ST_FULL;
        end else begin
          wr_req.en          = 1'b1;
          wr_req.entry.first = idx_q;
          wr_req.entry.last  = idx_q;
          wr_req.entry.tag   = tag_q;
          wr_addr            = count_q[AddrW-1:0];
          count_d            = count_q + CntW'(1);
          res_status_d       = rllm_pkg::ST_NEW;
        end
      end
      rllm_pkg::S_LK_SCAN: begin
        if (hit) begin
          res_tag_d    = rd_entry.tag;
          res_status_d = rllm_pkg::ST_OK;
        end else if (!last_slot) begin
          rd_en   = 1'b1;
          rd_addr = ptr_p1[AddrW-1:0];
          ptr_d   = ptr_p1[AddrW-1:0];
        end
      end
      rllm_pkg::S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_tdata_d = res_tag_q;
          m_tuser_d = res_status_q;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rllm_pkg::S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    idx_q        <= idx_d;
    tag_q        <= tag_d;
    res_tag_q    <= res_tag_d;
    res_status_q <= res_status_d;
    m_tdata_q    <= m_tdata_d;
    m_tuser_q    <= m_tuser_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_REGIONS))
    else $error("Region count exceeds the table depth.");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rllm_pkg::S_LK_SCAN) |-> (CntW'(ptr_q) < count_q))
    else $error("Lookup scan pointer beyond the stored regions.");

  a_ins_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rllm_pkg::S_INS_CHK) |-> !count_zero)
    else $error("Insert check entered with an empty table.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("Region count changed by other than one.");

  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rllm_pkg::S_OUT && res_status_q == rllm_pkg::ST_NEW) |-> !count_zero)
    else $error("New region reported with an empty table.");

endmodule
